[src/wfu_pkg.sv]
// constants shared by the websocket frame unmasker
// no dependencies
`default_nettype none

package wfu_pkg;

	// width of the data frame length and byte counters
	localparam int FRAME_LEN_BITS = 24;
	localparam int STREAM_BITS    = 31;
	localparam int MSG_LEN_BITS   = 64;
	localparam int HDR_SIZE_BITS  = 4;

	// websocket header codes
	localparam logic [3:0] OPCODE_TEXT  = 4'h1;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [3:0] HDR_BASE     = 4'd2;
	localparam logic [3:0] HDR_KEY      = 4'd4;
	localparam logic [3:0] EXT16_BYTES  = 4'd2;
	localparam logic [3:0] EXT64_BYTES  = 4'd8;

	// parser phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

endpackage

`default_nettype wire

[src/websocket_frame_unmasker_unit.sv]
// websocket frame deframer and unmasker, top level
// depends on wfu_pkg
`default_nettype none

// Takes the payload of HTTP/2 DATA frames one byte per item and parses one
// websocket header per DATA frame (opcode, mask bit, 7/16/64-bit length and
// optional 4-byte key). Only text frames give results: each payload byte is
// sent unmasked, the last one with tlast, and a zero-length text frame gives
// one empty-message item. Malformed, cut-short or non-text frames are dropped
// without a result. The block takes one item every clock while the output is
// not stalled; an item goes through an input register and a result register,
// and its result is loaded into the result register once that register is free
// or being read. Only a stalled m_axis_tready holds the pipeline back.
module websocket_frame_unmasker_unit
	import wfu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// data_byte [7:0], frame_length [31:8], stream_number [62:32], zero [63]
	input  wire logic [63:0] s_axis_tdata,
	// frame_start
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_stream [30:0], clear_byte [38:31], zero [39]
	output logic [39:0]      m_axis_tdata,
	// message_end
	output logic             m_axis_tlast,
	// empty_message
	output logic             m_axis_tuser
);

	localparam int FLB = FRAME_LEN_BITS;

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic [FLB-1:0]         flen_s1;
	logic [STREAM_BITS-1:0] strm_s1;

	// parser state
	logic [1:0]               phase_q;
	logic [FLB-1:0]           pos_q;
	logic [FLB-1:0]           hlen_q;
	logic [STREAM_BITS-1:0]   strm_q;
	logic [3:0]               op_q;
	logic                     mask_q;
	logic [MSG_LEN_BITS-1:0]  mlen_q;
	logic [31:0]              key_q;
	logic [HDR_SIZE_BITS-1:0] hs_q;
	logic [FLB-1:0]           left_q;

	// result register
	logic                   out_valid_q;
	logic [STREAM_BITS-1:0] out_strm_q;
	logic [7:0]             out_byte_q;
	logic                   out_end_q;
	logic                   out_empty_q;

	logic advance;
	logic proc;

	assign advance       = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata[7:0];
			flen_s1  <= s_axis_tdata[8 +: FLB];
			strm_s1  <= s_axis_tdata[62:32];
			start_s1 <= s_axis_tuser;
		end
	end

	// current state, with a frame start taking the place of the held frame
	logic [1:0]               cur_phase;
	logic [FLB-1:0]           cur_pos;
	logic [FLB-1:0]           cur_hlen;
	logic [STREAM_BITS-1:0]   cur_strm;
	logic [3:0]               cur_op;
	logic                     cur_mask;
	logic [MSG_LEN_BITS-1:0]  cur_mlen;
	logic [31:0]              cur_key;
	logic [HDR_SIZE_BITS-1:0] cur_hs;
	logic [FLB-1:0]           cur_left;

	always_comb begin
		if (start_s1) begin
			cur_phase = PH_HEADER;
			cur_pos   = '0;
			cur_hlen  = flen_s1;
			cur_strm  = strm_s1;
			cur_op    = '0;
			cur_mask  = 1'b0;
			cur_mlen  = '0;
			cur_key   = '0;
			cur_hs    = HDR_BASE;
			cur_left  = '0;
		end else begin
			cur_phase = phase_q;
			cur_pos   = pos_q;
			cur_hlen  = hlen_q;
			cur_strm  = strm_q;
			cur_op    = op_q;
			cur_mask  = mask_q;
			cur_mlen  = mlen_q;
			cur_key   = key_q;
			cur_hs    = hs_q;
			cur_left  = left_q;
		end
	end

	// next state and result of the item in the input register
	logic [1:0]               nxt_phase;
	logic [FLB-1:0]           nxt_pos;
	logic [3:0]               nxt_op;
	logic                     nxt_mask;
	logic [MSG_LEN_BITS-1:0]  nxt_mlen;
	logic [31:0]              nxt_key;
	logic [HDR_SIZE_BITS-1:0] nxt_hs;
	logic [FLB-1:0]           nxt_left;
	logic                     emit;
	logic [7:0]               emit_byte;
	logic                     emit_end;
	logic                     emit_empty;

	logic [HDR_SIZE_BITS-1:0] ext_old;
	logic [HDR_SIZE_BITS-1:0] ext_new;
	logic [6:0]               len7;
	logic [FLB-1:0]           pos_inc;
	logic [FLB-1:0]           room;
	logic                     too_long;
	logic [1:0]               kidx;
	logic [7:0]               kbyte;
	logic [FLB-1:0]           left_dec;

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_pos    = cur_pos;
		nxt_op     = cur_op;
		nxt_mask   = cur_mask;
		nxt_mlen   = cur_mlen;
		nxt_key    = cur_key;
		nxt_hs     = cur_hs;
		nxt_left   = cur_left;
		emit       = 1'b0;
		emit_byte  = '0;
		emit_end   = 1'b0;
		emit_empty = 1'b0;
		pos_inc    = cur_pos + FLB'(1);
		ext_old    = cur_hs - HDR_BASE - (cur_mask ? HDR_KEY : 4'd0);
		len7       = byte_s1[6:0];
		ext_new    = (len7 == LEN_EXT16) ? EXT16_BYTES :
			(len7 == LEN_EXT64) ? EXT64_BYTES : 4'd0;
		room       = '0;
		too_long   = 1'b0;
		kidx       = cur_pos[1:0] - cur_hs[1:0];
		left_dec   = cur_left - FLB'(1);
		case (kidx)
			2'd0:    kbyte = cur_key[31:24];
			2'd1:    kbyte = cur_key[23:16];
			2'd2:    kbyte = cur_key[15:8];
			default: kbyte = cur_key[7:0];
		endcase

		if (cur_phase != PH_IDLE) begin
			if (cur_pos >= cur_hlen) begin
				// byte beyond the data frame
				nxt_phase = PH_IDLE;
			end else begin
				nxt_pos = pos_inc;
				if (cur_phase == PH_HEADER) begin
					if (cur_pos == '0) begin
						nxt_op = byte_s1[3:0];
					end else begin
						// header fields
						if (cur_pos == FLB'(1)) begin
							nxt_mask = byte_s1[7];
							nxt_hs   = HDR_BASE + ext_new + (byte_s1[7] ? HDR_KEY : 4'd0);
							nxt_mlen = (len7 < LEN_EXT16) ?
								MSG_LEN_BITS'(len7) : '0;
						end else if (cur_pos < FLB'(HDR_BASE + ext_old)) begin
							nxt_mlen = {cur_mlen[MSG_LEN_BITS-9:0], byte_s1};
						end else begin
							nxt_key = {cur_key[23:0], byte_s1};
						end
						// header complete
						room     = cur_hlen - FLB'(nxt_hs);
						too_long = (|nxt_mlen[MSG_LEN_BITS-1:FLB]) ||
							(nxt_mlen[FLB-1:0] > room);
						if (pos_inc == FLB'(nxt_hs)) begin
							if (too_long || cur_op != OPCODE_TEXT) begin
								nxt_phase = PH_IDLE;
							end else if (nxt_mlen == '0) begin
								emit       = 1'b1;
								emit_end   = 1'b1;
								emit_empty = 1'b1;
								nxt_phase  = PH_IDLE;
							end else begin
								nxt_left  = nxt_mlen[FLB-1:0];
								nxt_phase = PH_PAYLOAD;
							end
						end
					end
				end else begin
					// payload byte
					emit      = 1'b1;
					emit_byte = byte_s1 ^ kbyte;
					nxt_left  = left_dec;
					if (left_dec == '0) begin
						emit_end  = 1'b1;
						nxt_phase = PH_IDLE;
					end
				end
			end
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			hlen_q  <= '0;
			strm_q  <= '0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			mlen_q  <= '0;
			key_q   <= '0;
			hs_q    <= HDR_BASE;
			left_q  <= '0;
		end else if (proc) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
			hlen_q  <= cur_hlen;
			strm_q  <= cur_strm;
			op_q    <= nxt_op;
			mask_q  <= nxt_mask;
			mlen_q  <= nxt_mlen;
			key_q   <= nxt_key;
			hs_q    <= nxt_hs;
			left_q  <= nxt_left;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_strm_q  <= cur_strm;
			out_byte_q  <= emit_byte;
			out_end_q   <= emit_end;
			out_empty_q <= emit_empty;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_byte_q, out_strm_q};
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = out_empty_q;

	// checks
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("empty message without end mark");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[38:31] == 8'd0))
		else $error("empty message carries a byte");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != '0))
		else $error("payload phase with no bytes left");

	a_payload_text: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (op_q == OPCODE_TEXT))
		else $error("payload phase on a non-text frame");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1))
		else $error("result without an item in the input register");

endmodule

`default_nettype wire
